// ----- hw/rtl/bb3_pkg.sv -----
`default_nettype none

package bb3_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [9:0]  FRAME_WIDTH_RST  = 10'd320;
  localparam logic [11:0] FRAME_HEIGHT_RST = 12'd240;

  // request commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // window column taps
  localparam logic [1:0] TAP_LEFT  = 2'd0;
  localparam logic [1:0] TAP_MID   = 2'd1;
  localparam logic [1:0] TAP_RIGHT = 2'd2;

  // channel masks and reciprocals for the divide by 3 and by 9
  localparam logic [5:0]  MASK5    = 6'h1F;
  localparam logic [5:0]  MASK6    = 6'h3F;
  localparam logic [11:0] RECIP3   = 12'd2731;  // 2^13 / 3, rounded up
  localparam logic [11:0] RECIP9   = 12'd3641;  // 2^15 / 9, rounded up

  typedef struct packed {
    logic        cmd;
    logic [15:0] pixel_in;
  } in_req_t;

  typedef struct packed {
    logic [15:0] blurred_pixel;
    logic        frame_end;
  } out_req_t;

  // controller to datapath
  typedef struct packed {
    logic       accept;
    logic       acc_clear;
    logic       fetch;
    logic [1:0] fetch_tap;
    logic       divide;
    logic       load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ready;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bb3_ctrl.sv -----
`default_nettype none

module bb3_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire bb3_pkg::dp_stat_t stat,
  output bb3_pkg::dp_cmd_t       cmd
);

  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    FETCH_L,
    FETCH_M,
    FETCH_R,
    SETTLE,
    DIVIDE,
    LOAD
  } state_t;

  state_t state;

  // input side is open only between items
  assign in_stall = (state != IDLE);

  // command decode
  always_comb begin
    cmd = '0;
    unique case (state)
      IDLE: begin
        cmd.accept = in_valid;
      end
      CHECK: begin
        cmd.acc_clear = stat.ready;
      end
      FETCH_L: begin
        cmd.fetch     = 1'b1;
        cmd.fetch_tap = bb3_pkg::TAP_LEFT;
      end
      FETCH_M: begin
        cmd.fetch     = 1'b1;
        cmd.fetch_tap = bb3_pkg::TAP_MID;
      end
      FETCH_R: begin
        cmd.fetch     = 1'b1;
        cmd.fetch_tap = bb3_pkg::TAP_RIGHT;
      end
      SETTLE: begin
      end
      DIVIDE: begin
        cmd.divide = 1'b1;
      end
      LOAD: begin
        cmd.load = !stat.out_busy;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE:    if (in_valid) state <= CHECK;
        CHECK:   state <= stat.ready ? FETCH_L : IDLE;
        FETCH_L: state <= FETCH_M;
        FETCH_M: state <= FETCH_R;
        FETCH_R: state <= SETTLE;
        SETTLE:  state <= DIVIDE;
        DIVIDE:  state <= LOAD;
        LOAD:    if (!stat.out_busy) state <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/bb3_datapath.sv -----
`default_nettype none

module bb3_datapath #(
  parameter int MAX_LINE_WIDTH = 512
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [bb3_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bb3_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire bb3_pkg::in_req_t                   in_req,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output bb3_pkg::out_req_t                       out_req,
  input  wire bb3_pkg::dp_cmd_t                   cmd,
  output bb3_pkg::dp_stat_t                       stat
);

  localparam int COL_W = $clog2(MAX_LINE_WIDTH);
  localparam int EW    = $clog2(MAX_LINE_WIDTH + 1);
  localparam int XW    = COL_W + 1;
  localparam int CW    = (EW > 10) ? EW : 10;

  // configuration registers
  logic [9:0]  frame_width;
  logic [11:0] frame_height;

  // positions
  logic [COL_W-1:0] in_col, out_col;
  logic [11:0]      in_row, out_row;
  logic [1:0]       in_sel, out_sel;
  logic             in_done;

  // line stores and read data
  logic [15:0] store_a [MAX_LINE_WIDTH];
  logic [15:0] store_b [MAX_LINE_WIDTH];
  logic [15:0] store_c [MAX_LINE_WIDTH];
  logic [15:0] rd_a, rd_b, rd_c;
  logic        rd_pend, rd_col_ok;

  // window sums and means
  logic [11:0] acc_r, acc_g, acc_b;
  logic [7:0]  q_r, q_g, q_b;

  function automatic logic [1:0] sel_inc(input logic [1:0] s);
    logic [1:0] r;
    unique case (s)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] sel_dec(input logic [1:0] s);
    logic [1:0] r;
    unique case (s)
      2'd1:    r = 2'd0;
      2'd2:    r = 2'd1;
      default: r = 2'd2;
    endcase
    return r;
  endfunction

  // truncating divide by an in-frame neighbour count
  function automatic logic [7:0] div_n(input logic [11:0] x, input logic [3:0] n);
    logic [23:0] p3, p9;
    logic [7:0]  q;
    p3 = 24'(x) * 24'(bb3_pkg::RECIP3);
    p9 = 24'(x) * 24'(bb3_pkg::RECIP9);
    unique case (n)
      4'd1:    q = x[7:0];
      4'd2:    q = x[8:1];
      4'd3:    q = p3[20:13];
      4'd4:    q = x[9:2];
      4'd6:    q = p3[21:14];
      4'd9:    q = p9[22:15];
      default: q = '0;
    endcase
    return q;
  endfunction

  // effective frame size
  logic [CW-1:0] fw_ext;
  logic [EW-1:0] eff_w;
  logic [11:0]   eff_h;

  always_comb begin
    fw_ext = CW'(frame_width);
    if (frame_width == '0) begin
      eff_w = EW'(1);
    end else if (fw_ext > CW'(MAX_LINE_WIDTH)) begin
      eff_w = EW'(MAX_LINE_WIDTH);
    end else begin
      eff_w = EW'(fw_ext);
    end
    eff_h = (frame_height == '0) ? 12'd1 : frame_height;
  end

  // neighbourhood bounds of the current output pixel
  logic       top_ok, bot_ok, left_ok, right_ok;
  logic [1:0] top_sel, bot_sel;
  logic [1:0] rows_n, cols_n;
  logic [3:0] nbr_n;
  logic       last;

  always_comb begin
    top_ok   = (out_row != '0);
    bot_ok   = (13'(out_row) + 13'd1) < 13'(eff_h);
    left_ok  = (out_col != '0);
    right_ok = (XW'(out_col) + XW'(1)) < XW'(eff_w);
    top_sel  = sel_dec(out_sel);
    bot_sel  = sel_inc(out_sel);
    rows_n   = 2'd1 + 2'(top_ok) + 2'(bot_ok);
    cols_n   = 2'd1 + 2'(left_ok) + 2'(right_ok);
    nbr_n    = 4'(rows_n) * 4'(cols_n);
    last     = !bot_ok && !right_ok;
  end

  // readiness: input has passed the lower right neighbour
  logic [11:0]      need_row;
  logic [COL_W-1:0] need_col;

  always_comb begin
    need_row   = bot_ok ? (out_row + 12'd1) : out_row;
    need_col   = right_ok ? (out_col + COL_W'(1)) : out_col;
    stat.ready = in_done || (in_row > need_row) ||
                 ((in_row == need_row) && (in_col > need_col));
    stat.out_busy = out_valid && out_stall;
  end

  // input position update for an accepted request
  logic [COL_W-1:0] base_col;
  logic [11:0]      base_row;
  logic [1:0]       base_sel;
  logic [XW-1:0]    col_inc;
  logic [12:0]      row_inc;
  logic             wr_en;

  always_comb begin
    base_col = in_done ? '0 : in_col;
    base_row = in_done ? '0 : in_row;
    base_sel = in_done ? '0 : in_sel;
    col_inc  = XW'(base_col) + XW'(1);
    row_inc  = 13'(base_row) + 13'd1;
    wr_en    = cmd.accept && (in_req.cmd == bb3_pkg::CMD_PIXEL);
  end

  // read address for a window column
  logic [COL_W-1:0] rd_addr;
  logic             tap_ok;

  always_comb begin
    unique case (cmd.fetch_tap)
      bb3_pkg::TAP_LEFT: begin
        rd_addr = left_ok ? (out_col - COL_W'(1)) : out_col;
        tap_ok  = left_ok;
      end
      bb3_pkg::TAP_RIGHT: begin
        rd_addr = right_ok ? (out_col + COL_W'(1)) : out_col;
        tap_ok  = right_ok;
      end
      default: begin
        rd_addr = out_col;
        tap_ok  = 1'b1;
      end
    endcase
  end

  // line store a
  always_ff @(posedge clk) begin
    if (wr_en && base_sel == 2'd0) begin
      store_a[base_col] <= in_req.pixel_in;
    end
    if (cmd.fetch) begin
      rd_a <= store_a[rd_addr];
    end
  end

  // line store b
  always_ff @(posedge clk) begin
    if (wr_en && base_sel == 2'd1) begin
      store_b[base_col] <= in_req.pixel_in;
    end
    if (cmd.fetch) begin
      rd_b <= store_b[rd_addr];
    end
  end

  // line store c
  always_ff @(posedge clk) begin
    if (wr_en && base_sel == 2'd2) begin
      store_c[base_col] <= in_req.pixel_in;
    end
    if (cmd.fetch) begin
      rd_c <= store_c[rd_addr];
    end
  end

  // pick a store's read data by row slot
  function automatic logic [15:0] pick(input logic [1:0] s, input logic [15:0] a,
                                       input logic [15:0] b, input logic [15:0] c);
    logic [15:0] r;
    unique case (s)
      2'd0:    r = a;
      2'd1:    r = b;
      default: r = c;
    endcase
    return r;
  endfunction

  // column sum of the fetched pixels, channels widened to 8 bits
  logic [15:0] px_t, px_m, px_b;
  logic [9:0]  col_r, col_g, col_b;

  always_comb begin
    px_t  = pick(top_sel, rd_a, rd_b, rd_c);
    px_m  = pick(out_sel, rd_a, rd_b, rd_c);
    px_b  = pick(bot_sel, rd_a, rd_b, rd_c);
    col_r = 10'({px_m[15:11], 3'b000});
    col_g = 10'({px_m[10:5], 2'b00});
    col_b = 10'({px_m[4:0], 3'b000});
    if (top_ok) begin
      col_r = col_r + 10'({px_t[15:11], 3'b000});
      col_g = col_g + 10'({px_t[10:5], 2'b00});
      col_b = col_b + 10'({px_t[4:0], 3'b000});
    end
    if (bot_ok) begin
      col_r = col_r + 10'({px_b[15:11], 3'b000});
      col_g = col_g + 10'({px_b[10:5], 2'b00});
      col_b = col_b + 10'({px_b[4:0], 3'b000});
    end
  end

  // window accumulate and divide
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.fetch;
    end
    rd_col_ok <= tap_ok;
    if (cmd.acc_clear) begin
      acc_r <= '0;
      acc_g <= '0;
      acc_b <= '0;
    end else if (rd_pend && rd_col_ok) begin
      acc_r <= acc_r + 12'(col_r);
      acc_g <= acc_g + 12'(col_g);
      acc_b <= acc_b + 12'(col_b);
    end
    if (cmd.divide) begin
      q_r <= div_n(acc_r, nbr_n);
      q_g <= div_n(acc_g, nbr_n);
      q_b <= div_n(acc_b, nbr_n);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.load) begin
      out_req.blurred_pixel <= {q_r[7:3] & bb3_pkg::MASK5[4:0],
                                q_g[7:2] & bb3_pkg::MASK6,
                                q_b[7:3] & bb3_pkg::MASK5[4:0]};
      out_req.frame_end     <= last;
    end
  end

  // configuration and frame positions
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bb3_pkg::FRAME_WIDTH_RST;
      frame_height <= bb3_pkg::FRAME_HEIGHT_RST;
      in_col       <= '0;
      in_row       <= '0;
      in_sel       <= '0;
      in_done      <= 1'b0;
      out_col      <= '0;
      out_row      <= '0;
      out_sel      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bb3_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg_data[9:0];
        bb3_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: begin
        end
      endcase
      in_col  <= '0;
      in_row  <= '0;
      in_sel  <= '0;
      in_done <= 1'b0;
      out_col <= '0;
      out_row <= '0;
      out_sel <= '0;
    end else if (wr_en) begin
      // a pixel after a finished frame starts the next one
      if (in_done) begin
        out_col <= '0;
        out_row <= '0;
        out_sel <= '0;
      end
      if (col_inc >= XW'(eff_w)) begin
        in_col <= '0;
        if (row_inc >= 13'(eff_h)) begin
          in_row  <= '0;
          in_sel  <= '0;
          in_done <= 1'b1;
        end else begin
          in_row  <= row_inc[11:0];
          in_sel  <= sel_inc(base_sel);
          in_done <= 1'b0;
        end
      end else begin
        in_col  <= col_inc[COL_W-1:0];
        in_row  <= base_row;
        in_sel  <= base_sel;
        in_done <= 1'b0;
      end
    end else if (cmd.load) begin
      if (last) begin
        out_col <= '0;
        out_row <= '0;
        out_sel <= '0;
        in_done <= 1'b0;
      end else if (!right_ok) begin
        out_col <= '0;
        out_row <= out_row + 12'd1;
        out_sel <= sel_inc(out_sel);
      end else begin
        out_col <= out_col + COL_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/box_blur_3x3_rgb565_unit.sv -----
// channel  handshake              payload
// input    in_valid / in_stall    in_req  (cmd, pixel_in)
// output   out_valid / out_stall  out_req (blurred_pixel, frame_end)
// config   cfg_we                 cfg_index, cfg_data
//
// a request that yields no pixel returns to idle after the readiness check; one that yields a pixel
// goes on to fetch the three window columns through the single read port of each
// of the three line stores, then to sum, divide and load of the output register.
// a finished pixel waits in the output register while the next request is taken;
// a request that needs the output register while it is still stalled holds there.
// rst is synchronous; it clears positions and restores the 320 x 240 frame size.
// line stores are not cleared: an output reads only entries its frame has written.
`default_nettype none

module box_blur_3x3_rgb565_unit #(
  parameter int MAX_LINE_WIDTH = 512
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire bb3_pkg::in_req_t               in_req,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output bb3_pkg::out_req_t                   out_req,
  input  wire logic                           cfg_we,
  input  wire logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data
);

  bb3_pkg::dp_cmd_t  cmd;
  bb3_pkg::dp_stat_t stat;

  // sequencer
  bb3_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // line stores, window sums and output register
  bb3_datapath #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire

// ----- tb/box_blur_3x3_rgb565_unit_test.sv -----
`default_nettype none

module box_blur_3x3_rgb565_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_DEPTH     = 512;
  localparam int SETTLE_CYCLES  = 24;
  localparam int RANDOM_PIXELS  = 800;
  localparam int CALM_FROM      = 200;
  localparam int CALM_TO        = 500;
  localparam int IDLE_PCT       = 38;

  typedef enum int {
    FRAME_CLEAN,
    FRAME_NOISY,
    FRAME_CUT,
    FRAME_SHORT_DRAIN
  } frame_kind_t;

  // predicts blurred pixels from accepted requests and checks them in order
  class box_blur_tracker_t;
    logic [15:0] rows [3][LINE_DEPTH];
    int unsigned width_reg;
    int unsigned height_reg;
    int unsigned in_row, in_col, out_row, out_col;
    bit          in_done;
    bb3_pkg::out_req_t pending_pixels[$];
    int unsigned mismatches;

    function new();
      foreach (rows[s, x]) rows[s][x] = 16'h0000;
      width_reg  = 32'(bb3_pkg::FRAME_WIDTH_RST);
      height_reg = 32'(bb3_pkg::FRAME_HEIGHT_RST);
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      in_row  = 0;
      in_col  = 0;
      out_row = 0;
      out_col = 0;
      in_done = 1'b0;
    endfunction

    // a zero register acts as one, width saturates at the store depth
    function int unsigned eff_width();
      int unsigned w;
      w = (width_reg == 0) ? 1 : width_reg;
      if (w > LINE_DEPTH) w = LINE_DEPTH;
      return w;
    endfunction

    function int unsigned eff_height();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    // any write starts a new frame
    function void write_reg(logic [bb3_pkg::CFG_IDX_W-1:0] idx,
                            logic [bb3_pkg::CFG_DATA_W-1:0] data);
      if (idx == bb3_pkg::CFG_FRAME_WIDTH) width_reg = 32'(data) & 32'h3FF;
      else if (idx == bb3_pkg::CFG_FRAME_HEIGHT) height_reg = 32'(data) & 32'hFFF;
      restart();
    endfunction

    // mean of the in-frame neighbours, channels widened to 8 bits
    function logic [15:0] mean_at(int unsigned r, int unsigned c, int unsigned w,
                                  int unsigned h);
      int unsigned r0, r1, c0, c1, rs, gs, bs, n;
      logic [15:0] px;
      r0 = (r == 0) ? 0 : r - 1;
      r1 = (r + 1 < h) ? r + 1 : h - 1;
      c0 = (c == 0) ? 0 : c - 1;
      c1 = (c + 1 < w) ? c + 1 : w - 1;
      rs = 0;
      gs = 0;
      bs = 0;
      n  = 0;
      for (int unsigned y = r0; y <= r1; y++) begin
        for (int unsigned x = c0; x <= c1; x++) begin
          px = rows[y % 3][x % LINE_DEPTH];
          rs += ((32'(px) >> 11) & 32'(bb3_pkg::MASK5)) << 3;
          gs += ((32'(px) >> 5) & 32'(bb3_pkg::MASK6)) << 2;
          bs += (32'(px) & 32'(bb3_pkg::MASK5)) << 3;
          n++;
        end
      end
      rs = rs / n;
      gs = gs / n;
      bs = bs / n;
      return 16'(((rs >> 3) << 11) | ((gs >> 2) << 5) | (bs >> 3));
    endfunction

    function void note_request(bb3_pkg::in_req_t req);
      int unsigned w, h, got, need, nr, nc;
      bb3_pkg::out_req_t res;
      bit last;
      w = eff_width();
      h = eff_height();
      if (req.cmd == bb3_pkg::CMD_PIXEL) begin
        // a pixel after a complete frame drops what is still owed
        if (in_done) restart();
        rows[in_row % 3][in_col % LINE_DEPTH] = req.pixel_in;
        in_col++;
        if (in_col >= w) begin
          in_col = 0;
          in_row++;
          if (in_row >= h) begin
            in_row  = 0;
            in_done = 1'b1;
          end
        end
      end
      // ready once the lower right neighbour has arrived
      got  = in_done ? w * h : in_row * w + in_col;
      nr   = (out_row + 1 < h) ? out_row + 1 : h - 1;
      nc   = (out_col + 1 < w) ? out_col + 1 : w - 1;
      need = nr * w + nc;
      if (got > need) begin
        last = (out_row == h - 1) && (out_col == w - 1);
        res.blurred_pixel = mean_at(out_row, out_col, w, h);
        res.frame_end     = last;
        pending_pixels.push_back(res);
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
        if (last) begin
          out_row = 0;
          out_col = 0;
          in_done = 1'b0;
        end
      end
    endfunction

    function void check_pixel(bb3_pkg::out_req_t got);
      bb3_pkg::out_req_t want;
      if (pending_pixels.size() == 0) begin
        $error("blurred_pixel %h frame_end %b with no request waiting",
               got.blurred_pixel, got.frame_end);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        if (got.blurred_pixel !== want.blurred_pixel) begin
          $error("blurred_pixel expected %h got %h", want.blurred_pixel, got.blurred_pixel);
          mismatches++;
        end
        if (got.frame_end !== want.frame_end) begin
          $error("frame_end expected %b got %b", want.frame_end, got.frame_end);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_stall;
  bb3_pkg::in_req_t               in_req;
  logic                           out_valid;
  logic                           out_stall;
  bb3_pkg::out_req_t              out_req;
  logic                           cfg_we;
  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data;

  box_blur_3x3_rgb565_unit #(
    .MAX_LINE_WIDTH(LINE_DEPTH)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  box_blur_tracker_t tracker = new();
  bit                calm = 1'b0;
  int unsigned       pixels_sent = 0;

  // clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // output side back-pressure
  always @(negedge clk) begin
    out_stall = calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
  end

  // result checking
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_pixel(out_req);
  end

  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // one request, entered and left at a falling edge
  task automatic send_request(input logic cmd, input logic [15:0] pix);
    calm = (pixels_sent >= CALM_FROM) && (pixels_sent < CALM_TO);
    while (!calm && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    in_req.cmd      = cmd;
    in_req.pixel_in = pix;
    do @(posedge clk); while (in_stall);
    tracker.note_request(in_req);
    if (cmd == bb3_pkg::CMD_PIXEL) pixels_sent++;
    @(negedge clk);
  endtask

  // let every owed pixel come out, then let the block settle
  task automatic wait_idle();
    in_valid = 1'b0;
    while (tracker.pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [bb3_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bb3_pkg::CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    tracker.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // one frame at the current size, with drains to flush it
  task automatic run_frame(input frame_kind_t kind);
    int unsigned w, h, total, stop, drains;
    w     = tracker.eff_width();
    h     = tracker.eff_height();
    total = w * h;
    stop  = (kind == FRAME_CUT) ? $urandom_range(total - 1) : total;
    for (int unsigned i = 0; i < stop; i++) begin
      if (kind == FRAME_NOISY && $urandom_range(9) == 0) begin
        send_request(bb3_pkg::CMD_DRAIN, rand_pixel());
      end
      send_request(bb3_pkg::CMD_PIXEL, rand_pixel());
    end
    // a single line owes at most one pixel after its last input
    case (kind)
      FRAME_CUT:         drains = $urandom_range(2);
      FRAME_SHORT_DRAIN: drains = $urandom_range(w);
      default:           drains = ((h > 1) ? w + 2 : 2) + $urandom_range(2);
    endcase
    repeat (drains) send_request(bb3_pkg::CMD_DRAIN, rand_pixel());
  endtask

  // stimulus
  initial begin
    logic [bb3_pkg::CFG_DATA_W-1:0] wd, hd;
    int unsigned pick, frames;
    bit big, last_big;
    frame_kind_t kind;

    rst       = 1'b1;
    in_valid  = 1'b0;
    in_req    = '0;
    out_stall = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = bb3_pkg::CFG_FRAME_WIDTH;
    cfg_data  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // drain with nothing ready, then a write in the middle of a frame
    send_request(bb3_pkg::CMD_DRAIN, 16'hFFFF);
    send_request(bb3_pkg::CMD_PIXEL, 16'h1234);
    send_request(bb3_pkg::CMD_PIXEL, 16'hEDCB);
    write_reg(bb3_pkg::CFG_FRAME_WIDTH, 12'd3);
    write_reg(bb3_pkg::CFG_FRAME_HEIGHT, 12'd3);

    // full 3x3 frame with channel extremes, flushed, one extra drain
    send_request(bb3_pkg::CMD_PIXEL, 16'h0000);
    send_request(bb3_pkg::CMD_PIXEL, 16'hFFFF);
    send_request(bb3_pkg::CMD_PIXEL, 16'hF800);
    send_request(bb3_pkg::CMD_PIXEL, 16'h07E0);
    send_request(bb3_pkg::CMD_PIXEL, 16'h001F);
    send_request(bb3_pkg::CMD_PIXEL, 16'hFFFF);
    send_request(bb3_pkg::CMD_PIXEL, 16'h0000);
    send_request(bb3_pkg::CMD_PIXEL, 16'hFFFF);
    send_request(bb3_pkg::CMD_PIXEL, 16'h5555);
    repeat (5) send_request(bb3_pkg::CMD_DRAIN, 16'h0000);

    // zero width and height act as a single pixel frame
    write_reg(bb3_pkg::CFG_FRAME_WIDTH, 12'd0);
    write_reg(bb3_pkg::CFG_FRAME_HEIGHT, 12'd0);
    send_request(bb3_pkg::CMD_PIXEL, 16'hFFFF);
    send_request(bb3_pkg::CMD_DRAIN, 16'hAAAA);

    // new pixel before the last owed output is drained
    write_reg(bb3_pkg::CFG_FRAME_WIDTH, 12'd2);
    write_reg(bb3_pkg::CFG_FRAME_HEIGHT, 12'd1);
    send_request(bb3_pkg::CMD_PIXEL, 16'hF81F);
    send_request(bb3_pkg::CMD_PIXEL, 16'h07E0);
    send_request(bb3_pkg::CMD_PIXEL, 16'hFFFF);
    send_request(bb3_pkg::CMD_DRAIN, 16'h0000);

    // width beyond the line store saturates, a tall frame at minimum width
    write_reg(bb3_pkg::CFG_FRAME_WIDTH, 12'hFFF);
    write_reg(bb3_pkg::CFG_FRAME_HEIGHT, 12'd1);
    run_frame(FRAME_CLEAN);
    write_reg(bb3_pkg::CFG_FRAME_WIDTH, 12'd0);
    write_reg(bb3_pkg::CFG_FRAME_HEIGHT, 12'd300);
    run_frame(FRAME_CLEAN);

    // random phases, mostly small frames
    pixels_sent = 0;
    last_big    = 1'b1;
    while (pixels_sent < RANDOM_PIXELS) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        wd = 12'($urandom_range(1, 8));
        hd = 12'($urandom_range(1, 6));
      end else if (pick < 85) begin
        wd = 12'($urandom_range(9, 40));
        hd = 12'($urandom_range(1, 4));
      end else if (pick < 93) begin
        wd = {2'($urandom), 10'($urandom_range(0, 6))};
        hd = 12'($urandom_range(0, 3));
      end else if (pick < 98) begin
        wd = 12'($urandom_range(1, 3));
        hd = 12'($urandom_range(20, 60));
      end else begin
        wd = 12'($urandom_range(500, 512));
        hd = 12'd1;
      end
      big = (pick >= 93);
      // size changes near a big frame always set both registers
      if (big || last_big) begin
        write_reg(bb3_pkg::CFG_FRAME_WIDTH, wd);
        write_reg(bb3_pkg::CFG_FRAME_HEIGHT, hd);
      end else begin
        case ($urandom_range(2))
          0: begin
            write_reg(bb3_pkg::CFG_FRAME_WIDTH, wd);
            write_reg(bb3_pkg::CFG_FRAME_HEIGHT, hd);
          end
          1:       write_reg(bb3_pkg::CFG_FRAME_WIDTH, wd);
          default: write_reg(bb3_pkg::CFG_FRAME_HEIGHT, hd);
        endcase
      end
      last_big = big;

      frames = $urandom_range(1, 3);
      for (int unsigned f = 0; f < frames; f++) begin
        pick = $urandom_range(99);
        if (pick < 55) kind = FRAME_CLEAN;
        else if (pick < 80) kind = FRAME_NOISY;
        else if (pick < 90) kind = FRAME_CUT;
        else kind = FRAME_SHORT_DRAIN;
        run_frame(kind);
        if (kind == FRAME_CUT) break;
      end
    end

    // wind down
    calm = 1'b0;
    wait_idle();
    if (tracker.mismatches == 0 && tracker.pending_pixels.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/bb3_pkg.sv
hw/rtl/bb3_ctrl.sv
hw/rtl/bb3_datapath.sv
hw/rtl/box_blur_3x3_rgb565_unit.sv
tb/box_blur_3x3_rgb565_unit_test.sv
